/* rtl/linear_probe_hash_table_top_assert.svh */
// Assertion macros used by the checker file
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

// Check that a property holds on every clock, outside reset
`define LPH_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a property holds on every clock, reset included
`define LPH_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* rtl/lph_pkg.sv */
package lph_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        RC_INSERTED = 3'd0,
        RC_UPDATED  = 3'd1,
        RC_REMOVED  = 3'd2,
        RC_FOUND    = 3'd3,
        RC_MISSING  = 3'd4,
        RC_FULL     = 3'd5
    } t_rc;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_LIVE  = 2'd1,
        ST_TOMB  = 2'd2
    } t_slot_st;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         result_code;
        logic signed [31:0] value_out;
    } t_out_item;

    localparam logic [31:0] GOLDEN_MULT = 32'd2654435769;
    localparam int          CFG_W       = 11;
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 11'd717;

endpackage

/* rtl/linear_probe_hash_table_top.sv */
// channel  | valid     | stall     | payload
// in       | i_valid   | o_stall   | i_item (mode, key, value)
// out      | o_valid   | i_stall   | o_item (result_code, value_out)
// cfg      | i_cfg_we  | -         | i_cfg_data (max_entries)
// An item goes through S_HASH, then P probes (P at most SLOTS), then S_DONE:
// every probe is one read of the slot memory (S_READ) and one compare (S_PROBE).
// After reset a clearing pass marks every slot empty;
// no item is taken until it ends. The result waits in an output register;
// a stalled output blocks the next item until taken.
module linear_probe_hash_table_top
    import lph_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_item         i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = AW + 1;

    logic [1:0]        mem_st  [SLOTS];
    logic [31:0]       mem_key [SLOTS];
    logic [31:0]       mem_val [SLOTS];

    t_state            r_state, n_state;
    t_in_item          r_item, n_item;
    logic [AW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_have_tomb, n_have_tomb;
    logic [AW-1:0]     r_tomb, n_tomb;
    logic [31:0]       r_mix;
    logic [CFG_W-1:0]  r_max;
    logic [CFG_W-1:0]  r_live, n_live;
    logic              r_oval, n_oval;
    t_out_item         r_out, n_out;

    logic [1:0]        r_rd_st;
    logic [31:0]       r_rd_key, r_rd_val;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [1:0]        wr_st;
    logic              wr_kv;
    logic              wr_v_only;
    logic [63:0]       scaled;
    logic [AW-1:0]     home;

    assign scaled = {32'd0, r_mix} * 64'(SLOTS);
    assign home   = AW'(scaled[63:32]);

    // memory: one write port, registered read at r_idx
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_st[wr_addr] <= wr_st;
        end
        if (wr_kv) begin
            mem_key[wr_addr] <= r_item.key;
        end
        if (wr_kv || wr_v_only) begin
            mem_val[wr_addr] <= r_item.value;
        end
        r_rd_st  <= mem_st[r_idx];
        r_rd_key <= mem_key[r_idx];
        r_rd_val <= mem_val[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_have_tomb <= 1'b0;
            r_max       <= MAX_ENTRIES_RESET;
            r_live      <= '0;
            r_oval      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_have_tomb <= n_have_tomb;
            r_live      <= n_live;
            r_oval      <= n_oval;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_tomb <= n_tomb;
        r_out  <= n_out;
        r_mix  <= n_item.key * GOLDEN_MULT;
    end

    always_comb begin
        logic is_ins;
        logic hit;
        logic last;
        is_ins      = (r_item.mode == MODE_INSERT);
        hit         = (r_rd_st == ST_LIVE) && (r_rd_key == r_item.key);
        last        = (r_cnt == CW'(SLOTS - 1));
        n_state     = r_state;
        n_item      = r_item;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_have_tomb = r_have_tomb;
        n_tomb      = r_tomb;
        n_live      = r_live;
        n_oval      = r_oval && i_stall;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_kv       = 1'b0;
        wr_v_only   = 1'b0;
        wr_addr     = r_idx;
        wr_st       = ST_EMPTY;
        o_stall     = 1'b1;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == AW'(SLOTS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall = n_oval;
                if (i_valid && !n_oval) begin
                    n_item      = i_item;
                    n_cnt       = '0;
                    n_have_tomb = 1'b0;
                    n_state     = S_HASH;
                end
            end
            S_HASH: begin
                n_idx   = home;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                n_out.value_out = '0;
                n_state         = S_DONE;
                if (hit) begin
                    case (r_item.mode)
                        MODE_INSERT: begin
                            wr_v_only         = 1'b1;
                            n_out.result_code = RC_UPDATED;
                        end
                        MODE_REMOVE: begin
                            wr_en             = 1'b1;
                            wr_st             = ST_TOMB;
                            n_live            = r_live - 1'b1;
                            n_out.result_code = RC_REMOVED;
                        end
                        default: begin
                            n_out.result_code = RC_FOUND;
                            n_out.value_out   = r_rd_val;
                        end
                    endcase
                end else if (r_rd_st == ST_EMPTY || last) begin
                    if (!is_ins) begin
                        n_out.result_code = RC_MISSING;
                    end else if (r_live >= r_max
                                 || (!r_have_tomb && r_rd_st != ST_EMPTY
                                     && !(r_rd_st == ST_TOMB))) begin
                        n_out.result_code = RC_FULL;
                    end else begin
                        wr_en             = 1'b1;
                        wr_kv             = 1'b1;
                        wr_st             = ST_LIVE;
                        wr_addr           = r_have_tomb ? r_tomb
                                          : r_idx;
                        n_live            = r_live + 1'b1;
                        n_out.result_code = RC_INSERTED;
                    end
                end else begin
                    if (r_rd_st == ST_TOMB && !r_have_tomb) begin
                        n_have_tomb = 1'b1;
                        n_tomb      = r_idx;
                    end
                    n_idx   = (r_idx == AW'(SLOTS - 1)) ? '0 : r_idx + 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_READ;
                end
                if (r_item.mode == MODE_NONE) begin
                    wr_en             = 1'b0;
                    wr_kv             = 1'b0;
                    wr_v_only         = 1'b0;
                    n_live            = r_live;
                    n_out.result_code = RC_MISSING;
                    n_out.value_out   = '0;
                    n_state           = S_DONE;
                end
            end
            S_DONE: begin
                n_oval  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_oval;
    assign o_item  = r_out;

endmodule

/* rtl/lph_checker.sv */
module lph_checker
    import lph_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);
`include "linear_probe_hash_table_top_assert.svh"

    `LPH_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_item))
    `LPH_ASSERT_CLK(a_code_range, i_clk, i_rst_n, o_valid |-> o_item.result_code <= RC_FULL)
    `LPH_ASSERT_CLK(a_vout_zero, i_clk, i_rst_n, o_valid && o_item.result_code != RC_FOUND |-> o_item.value_out == 0)
    `LPH_ASSERT_CLK(a_one_at_a_time, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall)
    `LPH_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind linear_probe_hash_table_top lph_checker u_lph_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import lph_pkg::*;

    localparam int NSLOTS = 1024;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    t_in_item         i_item = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    t_out_item        o_item;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    linear_probe_hash_table_top #(.SLOTS(NSLOTS)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // table mirror
    t_slot_st    tbl_st [NSLOTS];
    logic [31:0] tbl_key [NSLOTS];
    logic [31:0] tbl_val [NSLOTS];
    int unsigned live_cnt;
    int unsigned entry_limit;

    t_out_item   answers_due[$];
    logic [31:0] keys_used[$];
    int          mismatches = 0;
    bit          calm = 1'b0;

    function automatic int unsigned home_of(logic [31:0] k);
        logic [31:0] mixed;
        logic [63:0] scaled;
        mixed  = k * GOLDEN_MULT;
        scaled = {32'd0, mixed} * NSLOTS;
        return scaled[63:32];
    endfunction

    function automatic t_out_item apply_op(t_in_item it);
        t_out_item   r;
        int unsigned i;
        int unsigned tomb;
        int unsigned empty_at;
        bit          has_tomb;
        bit          has_empty;
        bit          hit;
        r = '{result_code: RC_MISSING, value_out: '0};
        i = home_of(it.key);
        has_tomb = 0;
        has_empty = 0;
        hit = 0;
        tomb = 0;
        empty_at = 0;
        for (int n = 0; n < NSLOTS; n++) begin
            if (tbl_st[i] == ST_EMPTY) begin
                has_empty = 1;
                empty_at = i;
                break;
            end
            if (tbl_st[i] == ST_LIVE && tbl_key[i] == it.key) begin
                hit = 1;
                break;
            end
            if (tbl_st[i] == ST_TOMB && !has_tomb) begin
                has_tomb = 1;
                tomb = i;
            end
            i = (i + 1) % NSLOTS;
        end
        case (t_mode'(it.mode))
            MODE_INSERT: begin
                if (hit) begin
                    tbl_val[i] = it.value;
                    r.result_code = RC_UPDATED;
                end else if (live_cnt >= entry_limit || (!has_tomb && !has_empty)) begin
                    r.result_code = RC_FULL;
                end else begin
                    i = has_tomb ? tomb : empty_at;
                    tbl_st[i] = ST_LIVE;
                    tbl_key[i] = it.key;
                    tbl_val[i] = it.value;
                    live_cnt = (live_cnt + 1) & 11'h7ff;
                    r.result_code = RC_INSERTED;
                end
            end
            MODE_REMOVE: begin
                if (hit) begin
                    tbl_st[i] = ST_TOMB;
                    live_cnt = (live_cnt - 1) & 11'h7ff;
                    r.result_code = RC_REMOVED;
                end
            end
            MODE_SEARCH: begin
                if (hit) begin
                    r.result_code = RC_FOUND;
                    r.value_out = tbl_val[i];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // receiver: random stall, check each item
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result code=%0d value=%0d",
                             o_item.result_code, o_item.value_out);
            end else begin
                want = answers_due.pop_front();
                if (o_item.result_code !== want.result_code
                        || o_item.value_out !== want.value_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want code=%0d value=%0d, got code=%0d value=%0d",
                                 want.result_code, want.value_out,
                                 o_item.result_code, o_item.value_out);
                end
            end
        end
        i_stall <= calm ? 1'b0 : ($urandom_range(99) < 12);
    end

    task automatic send_item(t_mode m, logic [31:0] k, logic [31:0] v);
        // drop valid after the previous item; unless calm, hold it low longer at random
        do @(posedge i_clk); while (!calm && $urandom_range(99) < 12);
        i_item  <= '{mode: m, key: k, value: v};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        answers_due.push_back(apply_op('{mode: m, key: k, value: v}));
        i_valid <= 1'b0;
    endtask

    task automatic drain_all();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_limit(int unsigned lim);
        drain_all();
        i_cfg_data <= lim[CFG_W-1:0];
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        entry_limit = lim & 11'h7ff;
    endtask

    function automatic logic [31:0] pick_key();
        if (keys_used.size() != 0 && $urandom_range(99) < 60)
            return keys_used[$urandom_range(keys_used.size() - 1)];
        return $urandom_range(3) == 0 ? $urandom() : $urandom_range(300) - 150;
    endfunction

    task automatic test_edges();
        logic [31:0] ext[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        foreach (ext[j]) begin
            send_item(MODE_INSERT, ext[j], ~ext[j]);
            keys_used.push_back(ext[j]);
        end
        foreach (ext[j]) send_item(MODE_SEARCH, ext[j], '0);
        send_item(MODE_INSERT, ext[0], 32'h1234_5678);
        send_item(MODE_REMOVE, ext[1], '0);
        send_item(MODE_REMOVE, ext[1], '0);
        send_item(MODE_SEARCH, ext[1], '0);
        send_item(MODE_NONE, ext[2], 32'hffff_ffff);
        send_item(MODE_INSERT, ext[1], 32'h5555_aaaa);
        send_item(MODE_SEARCH, ext[1], '0);
    endtask

    task automatic test_limit();
        // limit equal to the live count blocks new keys but still allows updates
        set_limit(live_cnt);
        send_item(MODE_INSERT, 32'd777, 32'd1);
        send_item(MODE_INSERT, 32'h8000_0000, 32'd9);
        set_limit(0);
        send_item(MODE_INSERT, 32'd778, 32'd2);
        send_item(MODE_SEARCH, 32'd778, '0);
        set_limit(1024);
    endtask

    task automatic test_random(int count, int ins_pct);
        int unsigned r;
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 3 && n < count / 2);
            r = $urandom_range(99);
            if (r < ins_pct) begin
                keys_used.push_back(pick_key());
                send_item(MODE_INSERT, keys_used[$], $urandom());
            end else if (r < ins_pct + (100 - ins_pct) / 2)
                send_item(MODE_SEARCH, pick_key(), $urandom());
            else if (r < 98)
                send_item(MODE_REMOVE, pick_key(), $urandom());
            else
                send_item(MODE_NONE, pick_key(), $urandom());
        end
        calm = 1'b0;
    endtask

    task automatic test_fill();
        // fill up to the limit and try past it, then churn with removes to build tombstones
        set_limit(40);
        test_random(120, 70);
        set_limit(2047);
        test_random(150, 45);
    endtask

    initial begin
        for (int j = 0; j < NSLOTS; j++) begin
            tbl_st[j] = ST_EMPTY;
            tbl_key[j] = '0;
            tbl_val[j] = '0;
        end
        live_cnt = 0;
        entry_limit = MAX_ENTRIES_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_edges();
        test_limit();
        test_random(150, 50);
        test_fill();
        drain_all();
        if (mismatches == 0 && answers_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #200ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/lph_pkg.sv
rtl/linear_probe_hash_table_top.sv
rtl/lph_checker.sv
tb/tb.sv
